### design/xxh_pkg.sv
package xxh_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = WORD_W / 2;

   localparam logic [WORD_W-1:0] PRIME1 = 64'd11400714785074694791;
   localparam logic [WORD_W-1:0] PRIME2 = 64'd14029467366897019727;
   localparam logic [WORD_W-1:0] PRIME3 = 64'd1609587929392839161;
   localparam logic [WORD_W-1:0] PRIME4 = 64'd9650029242287828579;
   localparam logic [WORD_W-1:0] PRIME5 = 64'd2870177450012600261;
   localparam logic [WORD_W-1:0] PRIME12 = PRIME1 + PRIME2;

   localparam logic [WORD_W-1:0] SEED_RESET = 64'h0000_0000_9f30_8856;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic CSR_IDX_SEED = 1'b0;

   localparam int unsigned STRIPE_BYTES = 32;
   localparam int unsigned FILL_W = $clog2(STRIPE_BYTES);
   localparam int unsigned POS_W = FILL_W + 1;
   localparam int unsigned LANES = 4;
   localparam int unsigned LANE_IDX_W = $clog2(LANES);

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } mul_req_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SUM    = 6'b000010,
      ST_ADDLEN = 6'b000100,
      ST_ISSUE  = 6'b001000,
      ST_MUL    = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      UOP_LANE_W,
      UOP_LANE_P,
      UOP_MRG_W,
      UOP_MRG_P,
      UOP_MRG_H,
      UOP_T8_W,
      UOP_T8_P,
      UOP_T8_H,
      UOP_T4,
      UOP_T4_H,
      UOP_T1,
      UOP_T1_H,
      UOP_AV1,
      UOP_AV2
   } uop_type;

   function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                input int unsigned r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

endpackage

### design/xxhash64_byte_stream_unit.sv
// A byte that neither completes a stripe nor ends the message is stored and ready stays high.
// The 32nd byte of a stripe runs 8 products on the shared multiplier to update the four lanes.
// A final byte runs the lane products if it completes a stripe, then lane sum and merge if a
// stripe was seen, length add, tail, avalanche; tail word 3 products, 4-byte word 2, byte 2.
// One request at a time; ready is low while a stripe or digest is in work and while a result waits.
// Reset: seed returns to 0x9f308856, fill, length and flags clear (lanes, hash not reset), no result pending.
module xxhash64_byte_stream_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] data_byte
   input  logic                                  req_tlast,
   input  logic                                  req_tuser,  // [0] empty_message
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [xxh_pkg::WORD_W-1:0]            rsp_tdata,  // [63:0] hash
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [xxh_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [xxh_pkg::WORD_W-1:0]            csr_pwdata,
   output logic [xxh_pkg::WORD_W-1:0]            csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned W   = xxh_pkg::WORD_W;
   localparam int unsigned PW  = xxh_pkg::POS_W;
   localparam int unsigned FW  = xxh_pkg::FILL_W;
   localparam int unsigned LIW = xxh_pkg::LANE_IDX_W;

   xxh_pkg::state_type state_ff, state_in;
   xxh_pkg::uop_type   uop_ff, uop_in;
   logic [LIW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [W-1:0]       len_ff, len_in;
   logic               seen_ff, seen_in;
   logic               last_ff, last_in;
   logic [W-1:0]       seed_ff, seed_in;
   logic [W-1:0]       h_ff, h_in;
   logic [W-1:0]       tmp_ff, tmp_in;
   logic [W-1:0]       lane_ff [xxh_pkg::LANES];
   logic [W-1:0]       lane_in [xxh_pkg::LANES];

   xxh_pkg::mul_req_type mul_req;
   logic                 mul_done;
   logic [W-1:0]         prod;

   logic               req_fire;
   logic               csr_wr;
   logic               buf_wr;
   logic [LIW-1:0]     buf_idx;
   logic [W-1:0]       buf_word;
   logic [7:0]         buf_byte;
   logic [W-1:0]       lane_rot;
   logic [PW-1:0]      pos_next;
   logic [PW-1:0]      fill_ext;
   xxh_pkg::uop_type   tail_uop;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == xxh_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == xxh_pkg::ST_OUT);
   assign rsp_tdata  = h_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[3] == xxh_pkg::CSR_IDX_SEED);
   assign csr_prdata = (csr_paddr[3] == xxh_pkg::CSR_IDX_SEED) ? seed_ff : '0;
   assign seed_in    = csr_wr ? csr_pwdata : seed_ff;

   assign buf_wr   = req_fire && !req_tuser;
   assign buf_idx  = (uop_ff == xxh_pkg::UOP_LANE_W) ? idx_ff : pos_ff[FW-1:3];
   assign buf_byte = buf_word[{pos_ff[2:0], 3'b000} +: 8];

   xxh_stripe_buf u_buf (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (fill_ff),
      .wr_byte (req_tdata),
      .rd_idx  (buf_idx),
      .rd_word (buf_word)
   );

   xxh_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (prod)
   );

   // operands of the shared multiplier for each step
   always_comb begin
      mul_req.start = (state_ff == xxh_pkg::ST_ISSUE);
      case (uop_ff)
         xxh_pkg::UOP_LANE_W: begin
            mul_req.a = buf_word;                     mul_req.b = xxh_pkg::PRIME2;
         end
         xxh_pkg::UOP_LANE_P: begin
            mul_req.a = tmp_ff;                       mul_req.b = xxh_pkg::PRIME1;
         end
         xxh_pkg::UOP_MRG_W: begin
            mul_req.a = lane_ff[idx_ff];              mul_req.b = xxh_pkg::PRIME2;
         end
         xxh_pkg::UOP_MRG_P: begin
            mul_req.a = tmp_ff;                       mul_req.b = xxh_pkg::PRIME1;
         end
         xxh_pkg::UOP_MRG_H: begin
            mul_req.a = h_ff;                         mul_req.b = xxh_pkg::PRIME1;
         end
         xxh_pkg::UOP_T8_W: begin
            mul_req.a = buf_word;                     mul_req.b = xxh_pkg::PRIME2;
         end
         xxh_pkg::UOP_T8_P: begin
            mul_req.a = tmp_ff;                       mul_req.b = xxh_pkg::PRIME1;
         end
         xxh_pkg::UOP_T8_H: begin
            mul_req.a = xxh_pkg::rotl64(h_ff, 27);    mul_req.b = xxh_pkg::PRIME1;
         end
         xxh_pkg::UOP_T4: begin
            mul_req.a = {{(W/2){1'b0}},
                         pos_ff[2] ? buf_word[W-1:W/2] : buf_word[W/2-1:0]};
            mul_req.b = xxh_pkg::PRIME1;
         end
         xxh_pkg::UOP_T4_H: begin
            mul_req.a = xxh_pkg::rotl64(h_ff, 23);    mul_req.b = xxh_pkg::PRIME2;
         end
         xxh_pkg::UOP_T1: begin
            mul_req.a = {{(W-8){1'b0}}, buf_byte};    mul_req.b = xxh_pkg::PRIME5;
         end
         xxh_pkg::UOP_T1_H: begin
            mul_req.a = xxh_pkg::rotl64(h_ff, 11);    mul_req.b = xxh_pkg::PRIME1;
         end
         xxh_pkg::UOP_AV1: begin
            mul_req.a = h_ff ^ (h_ff >> 33);          mul_req.b = xxh_pkg::PRIME2;
         end
         xxh_pkg::UOP_AV2: begin
            mul_req.a = h_ff ^ (h_ff >> 29);          mul_req.b = xxh_pkg::PRIME3;
         end
         default: begin
            mul_req.a = h_ff;                         mul_req.b = xxh_pkg::PRIME1;
         end
      endcase
   end

   always_comb begin
      case (idx_ff)
         2'd0:    lane_rot = xxh_pkg::rotl64(lane_ff[0], 1);
         2'd1:    lane_rot = xxh_pkg::rotl64(lane_ff[1], 7);
         2'd2:    lane_rot = xxh_pkg::rotl64(lane_ff[2], 12);
         default: lane_rot = xxh_pkg::rotl64(lane_ff[3], 18);
      endcase
   end

   // pick the next tail step from the position after this step
   assign fill_ext = {1'b0, fill_ff};
   always_comb begin
      if (pos_next + PW'(8) <= fill_ext) begin
         tail_uop = xxh_pkg::UOP_T8_W;
      end else if (pos_next + PW'(4) <= fill_ext) begin
         tail_uop = xxh_pkg::UOP_T4;
      end else if (pos_next < fill_ext) begin
         tail_uop = xxh_pkg::UOP_T1;
      end else begin
         tail_uop = xxh_pkg::UOP_AV1;
      end
   end

   always_comb begin
      case (uop_ff)
         xxh_pkg::UOP_T8_H: pos_next = pos_ff + PW'(8);
         xxh_pkg::UOP_T4_H: pos_next = pos_ff + PW'(4);
         xxh_pkg::UOP_T1_H: pos_next = pos_ff + PW'(1);
         default:           pos_next = pos_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      uop_in   = uop_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      last_in  = last_ff;
      h_in     = h_ff;
      tmp_in   = tmp_ff;
      lane_in  = lane_ff;

      unique case (state_ff)
         xxh_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  // drop any message in progress and hash zero bytes
                  fill_in  = '0;
                  len_in   = '0;
                  seen_in  = 1'b0;
                  pos_in   = '0;
                  h_in     = seed_ff + xxh_pkg::PRIME5;
                  state_in = xxh_pkg::ST_ADDLEN;
               end else begin
                  if (len_ff == '0 && fill_ff == '0 && !seen_ff) begin
                     lane_in[0] = seed_ff + xxh_pkg::PRIME12;
                     lane_in[1] = seed_ff + xxh_pkg::PRIME2;
                     lane_in[2] = seed_ff;
                     lane_in[3] = seed_ff - xxh_pkg::PRIME1;
                  end
                  len_in = len_ff + W'(1);
                  pos_in = '0;
                  idx_in = '0;
                  if (fill_ff == FW'(xxh_pkg::STRIPE_BYTES - 1)) begin
                     fill_in  = '0;
                     seen_in  = 1'b1;
                     last_in  = req_tlast;
                     uop_in   = xxh_pkg::UOP_LANE_W;
                     state_in = xxh_pkg::ST_ISSUE;
                  end else begin
                     fill_in = fill_ff + FW'(1);
                     if (req_tlast) begin
                        if (seen_ff) begin
                           state_in = xxh_pkg::ST_SUM;
                        end else begin
                           h_in     = seed_ff + xxh_pkg::PRIME5;
                           state_in = xxh_pkg::ST_ADDLEN;
                        end
                     end
                  end
               end
            end
         end

         xxh_pkg::ST_SUM: begin
            h_in = ((idx_ff == '0) ? '0 : h_ff) + lane_rot;
            if (idx_ff == LIW'(xxh_pkg::LANES - 1)) begin
               idx_in   = '0;
               uop_in   = xxh_pkg::UOP_MRG_W;
               state_in = xxh_pkg::ST_ISSUE;
            end else begin
               idx_in = idx_ff + LIW'(1);
            end
         end

         xxh_pkg::ST_ADDLEN: begin
            h_in     = h_ff + len_ff;
            uop_in   = tail_uop;
            state_in = xxh_pkg::ST_ISSUE;
         end

         xxh_pkg::ST_ISSUE: begin
            state_in = xxh_pkg::ST_MUL;
         end

         xxh_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = xxh_pkg::ST_ISSUE;
               case (uop_ff)
                  xxh_pkg::UOP_LANE_W: begin
                     tmp_in = xxh_pkg::rotl64(lane_ff[idx_ff] + prod, 31);
                     uop_in = xxh_pkg::UOP_LANE_P;
                  end
                  xxh_pkg::UOP_LANE_P: begin
                     lane_in[idx_ff] = prod;
                     if (idx_ff == LIW'(xxh_pkg::LANES - 1)) begin
                        idx_in   = '0;
                        state_in = last_ff ? xxh_pkg::ST_SUM : xxh_pkg::ST_IDLE;
                        last_in  = 1'b0;
                     end else begin
                        idx_in = idx_ff + LIW'(1);
                        uop_in = xxh_pkg::UOP_LANE_W;
                     end
                  end
                  xxh_pkg::UOP_MRG_W: begin
                     tmp_in = xxh_pkg::rotl64(prod, 31);
                     uop_in = xxh_pkg::UOP_MRG_P;
                  end
                  xxh_pkg::UOP_MRG_P: begin
                     h_in   = h_ff ^ prod;
                     uop_in = xxh_pkg::UOP_MRG_H;
                  end
                  xxh_pkg::UOP_MRG_H: begin
                     h_in = prod + xxh_pkg::PRIME4;
                     if (idx_ff == LIW'(xxh_pkg::LANES - 1)) begin
                        idx_in   = '0;
                        state_in = xxh_pkg::ST_ADDLEN;
                     end else begin
                        idx_in = idx_ff + LIW'(1);
                        uop_in = xxh_pkg::UOP_MRG_W;
                     end
                  end
                  xxh_pkg::UOP_T8_W: begin
                     tmp_in = xxh_pkg::rotl64(prod, 31);
                     uop_in = xxh_pkg::UOP_T8_P;
                  end
                  xxh_pkg::UOP_T8_P: begin
                     h_in   = h_ff ^ prod;
                     uop_in = xxh_pkg::UOP_T8_H;
                  end
                  xxh_pkg::UOP_T8_H: begin
                     h_in   = prod + xxh_pkg::PRIME4;
                     pos_in = pos_next;
                     uop_in = tail_uop;
                  end
                  xxh_pkg::UOP_T4: begin
                     h_in   = h_ff ^ prod;
                     uop_in = xxh_pkg::UOP_T4_H;
                  end
                  xxh_pkg::UOP_T4_H: begin
                     h_in   = prod + xxh_pkg::PRIME3;
                     pos_in = pos_next;
                     uop_in = tail_uop;
                  end
                  xxh_pkg::UOP_T1: begin
                     h_in   = h_ff ^ prod;
                     uop_in = xxh_pkg::UOP_T1_H;
                  end
                  xxh_pkg::UOP_T1_H: begin
                     h_in   = prod;
                     pos_in = pos_next;
                     uop_in = tail_uop;
                  end
                  xxh_pkg::UOP_AV1: begin
                     h_in   = prod;
                     uop_in = xxh_pkg::UOP_AV2;
                  end
                  xxh_pkg::UOP_AV2: begin
                     // digest done: clear the message and hold the result
                     h_in     = prod ^ (prod >> 32);
                     fill_in  = '0;
                     len_in   = '0;
                     seen_in  = 1'b0;
                     last_in  = 1'b0;
                     pos_in   = '0;
                     state_in = xxh_pkg::ST_OUT;
                  end
                  default: begin
                     state_in = xxh_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         xxh_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = xxh_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = xxh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      tmp_ff  <= tmp_in;
      lane_ff <= lane_in;
      if (reset) begin
         state_ff <= xxh_pkg::ST_IDLE;
         uop_ff   <= xxh_pkg::UOP_AV2;
         idx_ff   <= '0;
         pos_ff   <= '0;
         fill_ff  <= '0;
         len_ff   <= '0;
         seen_ff  <= 1'b0;
         last_ff  <= 1'b0;
         seed_ff  <= xxh_pkg::SEED_RESET;
      end else begin
         state_ff <= state_in;
         uop_ff   <= uop_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         last_ff  <= last_in;
         seed_ff  <= seed_in;
      end
   end

endmodule

### design/xxh_mul64.sv
module xxh_mul64 (
   input  logic                          clock,
   input  logic                          reset,
   input  xxh_pkg::mul_req_type          req,
   output logic                          done,
   output logic [xxh_pkg::WORD_W-1:0]    product
);

   logic [xxh_pkg::WORD_W-1:0] a_ff, a_in;
   logic [xxh_pkg::WORD_W-1:0] b_ff, b_in;
   logic [xxh_pkg::WORD_W-1:0] prod_ff, prod_in;
   logic [xxh_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic [1:0]                 step_ff, step_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [xxh_pkg::HALF_W-1:0] op_x, op_y;
   logic [xxh_pkg::WORD_W-1:0] mult;

   // low 64 bits of a*b from three 32x32 partial products
   always_comb begin
      case (step_ff)
         2'd1: begin
            op_x = a_ff[xxh_pkg::HALF_W-1:0];
            op_y = b_ff[xxh_pkg::WORD_W-1:xxh_pkg::HALF_W];
         end
         2'd2: begin
            op_x = a_ff[xxh_pkg::WORD_W-1:xxh_pkg::HALF_W];
            op_y = b_ff[xxh_pkg::HALF_W-1:0];
         end
         default: begin
            op_x = a_ff[xxh_pkg::HALF_W-1:0];
            op_y = b_ff[xxh_pkg::HALF_W-1:0];
         end
      endcase
      mult = {{xxh_pkg::HALF_W{1'b0}}, op_x} * {{xxh_pkg::HALF_W{1'b0}}, op_y};
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         step_in = 2'd0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         prod_in = mult;
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd1: acc_in = prod_ff;
            2'd2: acc_in = acc_ff + {prod_ff[xxh_pkg::HALF_W-1:0], {xxh_pkg::HALF_W{1'b0}}};
            2'd3: begin
               acc_in  = acc_ff + {prod_ff[xxh_pkg::HALF_W-1:0], {xxh_pkg::HALF_W{1'b0}}};
               run_in  = 1'b0;
               done_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         step_ff <= 2'd0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### design/xxh_stripe_buf.sv
module xxh_stripe_buf (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [xxh_pkg::FILL_W-1:0]        wr_addr,
   input  logic [7:0]                        wr_byte,
   input  logic [xxh_pkg::LANE_IDX_W-1:0]    rd_idx,
   output logic [xxh_pkg::WORD_W-1:0]        rd_word
);

   logic [xxh_pkg::WORD_W-1:0] word_ff [xxh_pkg::LANES];
   logic [xxh_pkg::WORD_W-1:0] word_in [xxh_pkg::LANES];

   // bytes land little-endian inside each 64-bit word
   always_comb begin
      word_in = word_ff;
      if (wr_en) begin
         word_in[wr_addr[xxh_pkg::FILL_W-1:3]][{wr_addr[2:0], 3'b000} +: 8] = wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rd_word = word_ff[rd_idx];

endmodule
